@@ src/omtp_pkg.sv @@
// Shared types, codes and character constants for the OBJ text parser.
// No dependencies.
`default_nettype none
package omtp_pkg;

    localparam int TOKEN_CHARS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int VAL_W             = 32;
    localparam int CNT_W             = 5;
    localparam int EXP_W             = 12;
    localparam int EXP_DIG_W         = 10;
    localparam logic [EXP_DIG_W-1:0] EXP_MAX = 10'd999;

    localparam logic [2:0] KIND_VCOORD = 3'd0;
    localparam logic [2:0] KIND_TCOORD = 3'd1;
    localparam logic [2:0] KIND_NCOORD = 3'd2;
    localparam logic [2:0] KIND_FVERT  = 3'd3;
    localparam logic [2:0] KIND_FTEX   = 3'd4;
    localparam logic [2:0] KIND_FNORM  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_BAD_CHAR = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_POINT = ".";
    localparam logic [7:0] CH_E     = "e";
    localparam logic [7:0] CH_HASH  = "#";
    localparam logic [7:0] CH_G     = "g";
    localparam logic [7:0] CH_S     = "s";
    localparam logic [7:0] CH_M     = "m";
    localparam logic [7:0] CH_F     = "f";
    localparam logic [7:0] CH_V     = "v";
    localparam logic [7:0] CH_T     = "t";
    localparam logic [7:0] CH_N     = "n";
    localparam logic [7:0] CH_P     = "p";
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";

    typedef enum logic [7:0] {
        LK_VX      = 8'b0000_0001,
        LK_V       = 8'b0000_0010,
        LK_VT      = 8'b0000_0100,
        LK_VN      = 8'b0000_1000,
        LK_VP      = 8'b0001_0000,
        LK_F       = 8'b0010_0000,
        LK_COMMENT = 8'b0100_0000,
        LK_EMPTY   = 8'b1000_0000
    } line_kind_t;

    typedef enum logic [8:0] {
        FP_TYPE = 9'b0_0000_0001,
        FP_D01  = 9'b0_0000_0010,
        FP_VAL1 = 9'b0_0000_0100,
        FP_D12  = 9'b0_0000_1000,
        FP_VAL2 = 9'b0_0001_0000,
        FP_D23  = 9'b0_0010_0000,
        FP_VAL3 = 9'b0_0100_0000,
        FP_D34  = 9'b0_1000_0000,
        FP_VAL4 = 9'b1_0000_0000
    } field_pos_t;

    typedef enum logic [2:0] {
        FS_VERTEX  = 3'b001,
        FS_TEXTURE = 3'b010,
        FS_NORMAL  = 3'b100
    } face_slot_t;

    typedef enum logic [14:0] {
        CS_IDLE   = 15'b000_0000_0000_0001,
        CS_SIGN   = 15'b000_0000_0000_0010,
        CS_MANT   = 15'b000_0000_0000_0100,
        CS_EXPE   = 15'b000_0000_0000_1000,
        CS_ESIGN  = 15'b000_0000_0001_0000,
        CS_EDIG   = 15'b000_0000_0010_0000,
        CS_SCALE  = 15'b000_0000_0100_0000,
        CS_MUL    = 15'b000_0000_1000_0000,
        CS_DBUILD = 15'b000_0001_0000_0000,
        CS_DPRE   = 15'b000_0010_0000_0000,
        CS_DRUN   = 15'b000_0100_0000_0000,
        CS_FFIN   = 15'b000_1000_0000_0000,
        CS_IDIG   = 15'b001_0000_0000_0000,
        CS_IFIN   = 15'b010_0000_0000_0000,
        CS_OUT    = 15'b100_0000_0000_0000
    } conv_state_t;

    typedef struct packed {
        logic       err;
        logic [1:0] err_code;
        logic       push;
        logic [2:0] kind;
        logic       idx_mode;
        logic       tok_append;
        logic       tok_clear;
    } lex_cmd_t;

    typedef struct packed {
        logic start;
        logic adv;
        logic set_neg;
        logic mant_digit;
        logic set_point;
        logic exp_neg;
        logic exp_digit;
        logic idx_digit;
        logic scale_init;
        logic mul_step;
        logic dbuild_step;
        logic dpre;
        logic drun_step;
        logic ffin;
        logic ifin;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic at_end;
        logic c_minus;
        logic c_digit;
        logic c_point;
        logic c_e;
        logic point_seen;
        logic digits_seen;
        logic idx_mode;
        logic e_pos;
        logic mul_done;
        logic dbuild_done;
        logic drun_last;
        logic out_free;
        logic tok_full;
    } dp_stat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

endpackage
`default_nettype wire

@@ src/omtp_lexer.sv @@
// Line type, field position and face slot machines; issues token and push commands.
// Depends on omtp_pkg.
`default_nettype none
module omtp_lexer (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  step,
    input  wire [7:0]            ch,
    input  wire                  tok_full,
    output omtp_pkg::lex_cmd_t   cmd
);
    import omtp_pkg::*;

    line_kind_t lt_reg, lt_next, lte;
    field_pos_t fp_reg, fp_next;
    face_slot_t fs_reg, fs_next;
    logic       halted_reg, halted_next;

    logic nl, sp, num, sep, v123;
    logic fail1, fail2, fail3, err;
    logic push_fp, push_fs, push_ok, idx_mode;
    logic append, clear;
    logic [2:0] kind;
    logic [1:0] code;
    logic live;

    always_comb begin
        nl  = (ch == CH_LF) || (ch == CH_CR);
        sp  = (ch == CH_SP) || (ch == CH_TAB);
        num = is_digit(ch) || (ch == CH_POINT) || (ch == CH_MINUS) || (ch == CH_E);
        sep = sp || nl || (ch == CH_SLASH);

        fail1   = 1'b0;
        lt_next = lt_reg;
        lte     = lt_reg;
        case (lt_reg)
            LK_EMPTY: begin
                if (nl || sp) begin
                    lt_next = LK_EMPTY;
                end else if (ch inside {CH_G, CH_S, CH_M, CH_HASH}) begin
                    lt_next = LK_COMMENT;
                end else if (ch == CH_F) begin
                    lt_next = LK_F;
                end else if (ch == CH_V) begin
                    lt_next = LK_VX;
                end else begin
                    fail1 = 1'b1;
                end
            end
            LK_VX: begin
                if (sp) begin
                    lte     = LK_V;
                    lt_next = LK_V;
                end else if (ch == CH_T) begin
                    lt_next = LK_VT;
                end else if (ch == CH_N) begin
                    lt_next = LK_VN;
                end else if (ch == CH_P) begin
                    lt_next = LK_VP;
                end else begin
                    fail1 = 1'b1;
                end
            end
            default: begin
                if (nl) lt_next = LK_EMPTY;
            end
        endcase

        push_fp = 1'b0;
        fp_next = fp_reg;
        case (fp_reg)
            FP_TYPE: begin
                if (lte inside {LK_V, LK_VT, LK_VN, LK_F}) begin
                    if (sp) fp_next = FP_D01;
                    else if (nl) fp_next = FP_TYPE;
                end
            end
            FP_D01: begin
                if (nl) fp_next = FP_TYPE;
                else if (!sp) fp_next = FP_VAL1;
            end
            FP_D12: begin
                if (nl) fp_next = FP_TYPE;
                else if (!sp) fp_next = FP_VAL2;
            end
            FP_D23: begin
                if (nl) fp_next = FP_TYPE;
                else if (!sp) fp_next = FP_VAL3;
            end
            FP_D34: begin
                if (nl) fp_next = FP_TYPE;
                else if (!sp) fp_next = FP_VAL4;
            end
            FP_VAL1: begin
                push_fp = sp || nl;
                if (sp) fp_next = FP_D12;
                else if (nl) fp_next = FP_TYPE;
            end
            FP_VAL2: begin
                push_fp = sp || nl;
                if (sp) fp_next = FP_D23;
                else if (nl) fp_next = FP_TYPE;
            end
            FP_VAL3: begin
                push_fp = sp || nl;
                if (sp) fp_next = FP_D34;
                else if (nl) fp_next = FP_TYPE;
            end
            FP_VAL4: begin
                push_fp = nl;
                if (nl) fp_next = FP_TYPE;
            end
            default: fp_next = FP_TYPE;
        endcase

        push_fs = 1'b0;
        fs_next = fs_reg;
        case (fs_reg)
            FS_VERTEX: begin
                if (ch == CH_SLASH) begin
                    push_fs = 1'b1;
                    fs_next = FS_TEXTURE;
                end
            end
            FS_TEXTURE: begin
                if (ch == CH_SLASH) begin
                    push_fs = 1'b1;
                    fs_next = FS_NORMAL;
                end else if (sp || nl) begin
                    fs_next = FS_VERTEX;
                end
            end
            default: begin
                if (sp || nl) fs_next = FS_VERTEX;
            end
        endcase

        v123     = fp_reg inside {FP_VAL1, FP_VAL2, FP_VAL3};
        push_ok  = 1'b1;
        idx_mode = 1'b0;
        kind     = KIND_VCOORD;
        if (lte == LK_V && v123) begin
            kind = KIND_VCOORD;
        end else if (lte == LK_F) begin
            idx_mode = 1'b1;
            case (fs_reg)
                FS_VERTEX:  kind = KIND_FVERT;
                FS_TEXTURE: kind = KIND_FTEX;
                default:    kind = KIND_FNORM;
            endcase
        end else if (lte == LK_VT && (fp_reg == FP_VAL1 || fp_reg == FP_VAL2)) begin
            kind = KIND_TCOORD;
        end else if (lte == LK_VN && v123) begin
            kind = KIND_NCOORD;
        end else begin
            push_ok = 1'b0;
        end

        fail2  = 1'b0;
        fail3  = 1'b0;
        append = 1'b0;
        clear  = 1'b0;
        if (lte != LK_COMMENT && fp_reg != FP_TYPE) begin
            if (num) begin
                if (tok_full) fail3 = 1'b1;
                else append = 1'b1;
            end else if (sep) begin
                clear = 1'b1;
            end else begin
                fail2 = 1'b1;
            end
        end

        err  = fail1 || fail2 || fail3;
        code = fail1 ? ST_BAD_TYPE : (fail2 ? ST_BAD_CHAR : ST_TOO_LONG);
        live = step && !halted_reg;

        cmd.err        = live && err;
        cmd.err_code   = code;
        cmd.push       = live && !err && (push_fp || push_fs) && push_ok;
        cmd.kind       = kind;
        cmd.idx_mode   = idx_mode;
        cmd.tok_append = live && !err && append;
        cmd.tok_clear  = live && !err && clear;

        halted_next = halted_reg || (live && err);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lt_reg     <= LK_EMPTY;
            fp_reg     <= FP_TYPE;
            fs_reg     <= FS_VERTEX;
            halted_reg <= 1'b0;
        end else begin
            halted_reg <= halted_next;
            if (live && !err) begin
                lt_reg <= lt_next;
                fp_reg <= fp_next;
                fs_reg <= fs_next;
            end
        end
    end

endmodule
`default_nettype wire

@@ src/omtp_ctrl.sv @@
// Conversion sequencer: walks the token and steps the scaling and division loops.
// Depends on omtp_pkg.
`default_nettype none
module omtp_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  start,
    input  omtp_pkg::dp_stat_t   stat,
    output omtp_pkg::dp_cmd_t    cmd,
    output logic                 in_ready
);
    import omtp_pkg::*;

    conv_state_t state_reg, state_next;
    logic avail;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        avail      = !stat.at_end;
        in_ready   = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                in_ready = stat.out_free;
                if (start) begin
                    cmd.start  = 1'b1;
                    state_next = CS_SIGN;
                end
            end
            CS_SIGN: begin
                if (avail && stat.c_minus) begin
                    cmd.set_neg = 1'b1;
                    cmd.adv     = 1'b1;
                end
                state_next = stat.idx_mode ? CS_IDIG : CS_MANT;
            end
            CS_MANT: begin
                if (avail && stat.c_digit) begin
                    cmd.mant_digit = 1'b1;
                    cmd.adv        = 1'b1;
                end else if (avail && stat.c_point && !stat.point_seen) begin
                    cmd.set_point = 1'b1;
                    cmd.adv       = 1'b1;
                end else begin
                    state_next = CS_EXPE;
                end
            end
            CS_EXPE: begin
                if (!stat.digits_seen) begin
                    state_next = CS_FFIN;
                end else if (avail && stat.c_e) begin
                    cmd.adv    = 1'b1;
                    state_next = CS_ESIGN;
                end else begin
                    state_next = CS_SCALE;
                end
            end
            CS_ESIGN: begin
                if (avail && stat.c_minus) begin
                    cmd.exp_neg = 1'b1;
                    cmd.adv     = 1'b1;
                end
                state_next = CS_EDIG;
            end
            CS_EDIG: begin
                if (avail && stat.c_digit) begin
                    cmd.exp_digit = 1'b1;
                    cmd.adv       = 1'b1;
                end else begin
                    state_next = CS_SCALE;
                end
            end
            CS_SCALE: begin
                cmd.scale_init = 1'b1;
                state_next     = stat.e_pos ? CS_MUL : CS_DBUILD;
            end
            CS_MUL: begin
                if (stat.mul_done) state_next = CS_FFIN;
                else cmd.mul_step = 1'b1;
            end
            CS_DBUILD: begin
                if (stat.dbuild_done) state_next = CS_DPRE;
                else cmd.dbuild_step = 1'b1;
            end
            CS_DPRE: begin
                cmd.dpre   = 1'b1;
                state_next = CS_DRUN;
            end
            CS_DRUN: begin
                cmd.drun_step = 1'b1;
                if (stat.drun_last) state_next = CS_FFIN;
            end
            CS_FFIN: begin
                cmd.ffin   = 1'b1;
                state_next = CS_OUT;
            end
            CS_IDIG: begin
                if (avail && stat.c_digit) begin
                    cmd.idx_digit = 1'b1;
                    cmd.adv       = 1'b1;
                end else begin
                    state_next = CS_IFIN;
                end
            end
            CS_IFIN: begin
                cmd.ifin   = 1'b1;
                state_next = CS_OUT;
            end
            CS_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ src/omtp_dp.sv @@
// Token buffer, number conversion datapath and result register.
// Depends on omtp_pkg.
`default_nettype none
module omtp_dp #(
    parameter int TOKEN_CHARS   = omtp_pkg::TOKEN_CHARS_DEF,
    parameter int FRACTION_BITS = omtp_pkg::FRACTION_BITS_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire [7:0]                     ch,
    input  omtp_pkg::lex_cmd_t            lex,
    input  omtp_pkg::dp_cmd_t             cmd,
    output omtp_pkg::dp_stat_t            stat,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [2:0]                    m_kind,
    output logic signed [omtp_pkg::VAL_W-1:0] m_value,
    output logic [1:0]                    m_status
);
    import omtp_pkg::*;

    localparam int LW = $clog2(TOKEN_CHARS + 1);
    localparam int AW = $clog2(TOKEN_CHARS);
    localparam int MW = (TOKEN_CHARS * 3322) / 1000 + 1;
    localparam int BW = MW + FRACTION_BITS + 4;
    localparam int DW = BW + 4;
    localparam int SW = DW + VAL_W - 1;

    logic [7:0]           tok_mem [TOKEN_CHARS];
    logic [7:0]           cur_reg;
    logic [LW-1:0]        tok_len_reg, tok_len_next;
    logic [LW-1:0]        n_reg, i_reg;
    logic [2:0]           kind_reg;
    logic                 idx_reg, neg_reg, point_reg, digits_reg, eneg_reg;
    logic [LW-1:0]        frac_reg;
    logic [EXP_DIG_W-1:0] exp_reg;
    logic [MW-1:0]        mant_reg;
    logic [VAL_W-1:0]     ival_reg;
    logic [BW-1:0]        big_reg, rem_reg;
    logic signed [EXP_W-1:0] e_reg;
    logic [EXP_W-1:0]     k_reg;
    logic [DW-1:0]        d_reg;
    logic [SW-1:0]        ds_reg;
    logic [VAL_W-1:0]     q_reg, res_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 sat_reg, use_div_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [2:0]           m_kind_reg;
    logic [VAL_W-1:0]     m_value_reg;
    logic [1:0]           m_status_reg;

    logic [LW-1:0]           rd_addr;
    logic [7:0]              cur;
    logic [3:0]              dig;
    logic signed [EXP_W-1:0] exp_s, e_comb, e_neg;
    logic [13:0]             exp_t;
    logic [VAL_W+3:0]        ival_t;
    logic                    big_hi, ge;
    logic [VAL_W:0]          mag, mag_n;
    logic [VAL_W-1:0]        fres;
    logic signed [VAL_W+1:0] sv;
    logic [VAL_W-1:0]        ires;
    logic                    out_free;

    always_comb begin
        rd_addr = cmd.start ? '0 : (cmd.adv ? i_reg + 1'b1 : i_reg);
        cur    = cur_reg;
        dig    = cur[3:0];
        exp_s  = signed'(EXP_W'(exp_reg));
        if (eneg_reg) exp_s = -exp_s;
        e_comb = exp_s - signed'(EXP_W'(frac_reg));
        e_neg  = -e_reg;
        exp_t  = {exp_reg, 3'b000} + {3'b000, exp_reg, 1'b0} + 14'(dig);
        ival_t = {ival_reg, 3'b000} + {2'b00, ival_reg, 1'b0} + (VAL_W+4)'(dig);
        big_hi = |big_reg[BW-1:VAL_W];
        ge     = SW'(rem_reg) >= ds_reg;

        if (!digits_reg) begin
            mag = '0;
        end else if (use_div_reg) begin
            mag = sat_reg ? {1'b1, {VAL_W{1'b0}}} : {1'b0, q_reg};
        end else begin
            mag = big_hi ? {1'b1, {VAL_W{1'b0}}} : {1'b0, big_reg[VAL_W-1:0]};
        end
        mag_n = (mag > {2'b01, {(VAL_W-1){1'b0}}}) ? {2'b01, {(VAL_W-1){1'b0}}} : mag;
        if (!neg_reg) begin
            fres = (mag > {2'b00, {(VAL_W-1){1'b1}}}) ? {1'b0, {(VAL_W-1){1'b1}}}
                                                     : mag[VAL_W-1:0];
        end else begin
            fres = ~mag_n[VAL_W-1:0] + 1'b1;
        end

        if (neg_reg) begin
            sv = -signed'({2'b00, ival_reg});
        end else if (ival_reg[VAL_W-1]) begin
            sv = signed'({3'b000, {(VAL_W-1){1'b1}}});
        end else begin
            sv = signed'({2'b00, ival_reg});
        end
        sv = sv - signed'((VAL_W+2)'(1));
        if (sv < -signed'({3'b001, {(VAL_W-1){1'b0}}})) begin
            ires = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            ires = sv[VAL_W-1:0];
        end

        out_free = !m_valid_reg || m_ready;

        stat.at_end      = i_reg >= n_reg;
        stat.c_minus     = cur == CH_MINUS;
        stat.c_digit     = is_digit(cur);
        stat.c_point     = cur == CH_POINT;
        stat.c_e         = cur == CH_E;
        stat.point_seen  = point_reg;
        stat.digits_seen = digits_reg;
        stat.idx_mode    = idx_reg;
        stat.e_pos       = e_comb > 0;
        stat.mul_done    = (k_reg == e_reg) || big_hi || (big_reg == '0);
        stat.dbuild_done = (k_reg == e_neg) || (DW'(big_reg) < d_reg);
        stat.drun_last   = cnt_reg == {CNT_W{1'b1}};
        stat.out_free    = out_free;
        stat.tok_full    = tok_len_reg >= LW'(TOKEN_CHARS);

        tok_len_next = tok_len_reg;
        if (lex.tok_clear) tok_len_next = '0;
        else if (lex.tok_append) tok_len_next = tok_len_reg + 1'b1;

        m_valid_next = m_valid_reg && !m_ready;
        if (lex.err || cmd.out_load) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (lex.tok_append) tok_mem[tok_len_reg[AW-1:0]] <= ch;
        cur_reg <= tok_mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_len_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            tok_len_reg <= tok_len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            n_reg       <= tok_len_reg;
            i_reg       <= '0;
            kind_reg    <= lex.kind;
            idx_reg     <= lex.idx_mode;
            neg_reg     <= 1'b0;
            point_reg   <= 1'b0;
            digits_reg  <= 1'b0;
            eneg_reg    <= 1'b0;
            frac_reg    <= '0;
            exp_reg     <= '0;
            mant_reg    <= '0;
            ival_reg    <= '0;
            use_div_reg <= 1'b0;
        end
        if (cmd.adv) i_reg <= i_reg + 1'b1;
        if (cmd.set_neg) neg_reg <= 1'b1;
        if (cmd.set_point) point_reg <= 1'b1;
        if (cmd.exp_neg) eneg_reg <= 1'b1;
        if (cmd.mant_digit) begin
            mant_reg   <= {mant_reg[MW-4:0], 3'b000} + {mant_reg[MW-2:0], 1'b0} + MW'(dig);
            digits_reg <= 1'b1;
            if (point_reg) frac_reg <= frac_reg + 1'b1;
        end
        if (cmd.exp_digit) begin
            exp_reg <= (exp_t > 14'(EXP_MAX)) ? EXP_MAX : exp_t[EXP_DIG_W-1:0];
        end
        if (cmd.idx_digit) begin
            ival_reg <= (ival_t > (VAL_W+4)'({1'b1, {(VAL_W-1){1'b0}}}))
                        ? {1'b1, {(VAL_W-1){1'b0}}} : ival_t[VAL_W-1:0];
        end
        if (cmd.scale_init) begin
            big_reg <= BW'(mant_reg) << FRACTION_BITS;
            e_reg   <= e_comb;
            k_reg   <= '0;
            d_reg   <= DW'(1);
        end
        if (cmd.mul_step) begin
            big_reg <= {big_reg[BW-4:0], 3'b000} + {big_reg[BW-2:0], 1'b0};
            k_reg   <= k_reg + 1'b1;
        end
        if (cmd.dbuild_step) begin
            d_reg <= {d_reg[DW-4:0], 3'b000} + {d_reg[DW-2:0], 1'b0};
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.dpre) begin
            sat_reg     <= {d_reg, {VAL_W{1'b0}}} <= (DW+VAL_W)'(big_reg);
            rem_reg     <= big_reg;
            ds_reg      <= {d_reg, {(VAL_W-1){1'b0}}};
            q_reg       <= '0;
            cnt_reg     <= '0;
            use_div_reg <= 1'b1;
        end
        if (cmd.drun_step) begin
            if (ge) rem_reg <= rem_reg - ds_reg[BW-1:0];
            q_reg   <= {q_reg[VAL_W-2:0], ge};
            ds_reg  <= ds_reg >> 1;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.ffin) res_reg <= fres;
        if (cmd.ifin) res_reg <= ires;
        if (lex.err) begin
            m_kind_reg   <= KIND_VCOORD;
            m_value_reg  <= '0;
            m_status_reg <= lex.err_code;
        end else if (cmd.out_load) begin
            m_kind_reg   <= kind_reg;
            m_value_reg  <= res_reg;
            m_status_reg <= ST_OK;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_kind   = m_kind_reg;
    assign m_value  = signed'(m_value_reg);
    assign m_status = m_status_reg;

endmodule
`default_nettype wire

@@ src/obj_mesh_text_parser_core.sv @@
// OBJ text parser top level: s_ channel takes one text byte, m_ channel gives
// coordinate, index or error results. Depends on omtp_pkg, omtp_lexer, omtp_ctrl, omtp_dp.
//
// Usage:
//   s_ch is one byte of OBJ text, taken when s_valid and s_ready are high.
//   m_kind/m_value/m_status is one result, a transfer when m_valid and m_ready.
//   A byte that ends a number field (space, tab, newline, '/') may yield a
//   vertex/texture/normal coordinate (signed fixed point) or a face index.
// Flow:
//   Bytes with no result, or with an error result, start no conversion.
//   Index result: sign and digits are scanned, then the result is finished and loaded.
//   Coordinate result: sign, mantissa and exponent scan, a setup step, then for a
//   positive exponent multiply-by-ten steps; otherwise the power of ten is built,
//   the divider is preset and the restoring divider runs; then the result is
//   finished and loaded into the output.
// Reset: aresetn low clears line state, token length, error halt and output valid.
// After an error result every byte is taken and ignored until reset.
// Stall: a result waits in the output register; a new byte is taken only when
// that register is empty or being read in the same cycle.
`default_nettype none
module obj_mesh_text_parser_core #(
    parameter int TOKEN_CHARS   = omtp_pkg::TOKEN_CHARS_DEF,
    parameter int FRACTION_BITS = omtp_pkg::FRACTION_BITS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire [7:0]                         s_ch,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [2:0]                        m_kind,
    output logic signed [omtp_pkg::VAL_W-1:0] m_value,
    output logic [1:0]                        m_status
);
    import omtp_pkg::*;

    lex_cmd_t lex;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     accept;

    assign accept = s_valid && s_ready;

    omtp_lexer u_lexer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (accept),
        .ch       (s_ch),
        .tok_full (stat.tok_full),
        .cmd      (lex)
    );

    omtp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (lex.push),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (s_ready)
    );

    omtp_dp #(
        .TOKEN_CHARS   (TOKEN_CHARS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ch       (s_ch),
        .lex      (lex),
        .cmd      (cmd),
        .stat     (stat),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_kind   (m_kind),
        .m_value  (m_value),
        .m_status (m_status)
    );

endmodule
`default_nettype wire
